FILE: rtl/cphs_pkg.sv
// Shared types, constants and helper functions of the corner-pin homography solver.
`timescale 1ns / 1ps
package cphs_pkg;

    localparam int COORD_FRAC_BITS  = 12;
    localparam int MATRIX_FRAC_BITS = 40;
    localparam int SINGULAR_LSBS    = 256;
    localparam int WW               = 200;
    localparam int MUL_BITS         = 66;
    localparam int DIV_NUM_BITS     = 112;
    localparam int DIV_DEN_BITS     = 69;
    localparam int CNT_W            = $clog2(DIV_NUM_BITS);
    localparam int QDEPTH           = 4;
    localparam int QPTR_W           = $clog2(QDEPTH);
    localparam int TOL_W            = 16;
    localparam int CFG_IDX_W        = 2;

    typedef logic signed [WW-1:0] t_wide;

    localparam t_wide W_ONE      = t_wide'(1) << MATRIX_FRAC_BITS;
    localparam t_wide W_SING_LIM = t_wide'(SINGULAR_LSBS) << (2 * MATRIX_FRAC_BITS);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_DEGEN    = 3'd2,
        ST_HORIZON  = 3'd3,
        ST_SINGULAR = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AFFINE_TOL   = 2'd0,
        CFG_SINGULAR_TOL = 2'd1,
        CFG_SIDE_TOL     = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    typedef struct packed {
        logic signed [31:0] corner0_x;
        logic signed [31:0] corner0_y;
        logic signed [31:0] corner1_x;
        logic signed [31:0] corner1_y;
        logic signed [31:0] corner2_x;
        logic signed [31:0] corner2_y;
        logic signed [31:0] corner3_x;
        logic signed [31:0] corner3_y;
        logic signed [31:0] rect_min_x;
        logic signed [31:0] rect_min_y;
        logic signed [31:0] rect_max_x;
        logic signed [31:0] rect_max_y;
    } t_in;

    typedef struct packed {
        logic signed [63:0] m00;
        logic signed [63:0] m01;
        logic signed [63:0] m02;
        logic signed [63:0] m10;
        logic signed [63:0] m11;
        logic signed [63:0] m12;
        logic signed [63:0] m20;
        logic signed [63:0] m21;
        logic signed [63:0] m22;
        logic [2:0]         status;
    } t_out;

    typedef struct packed {
        logic               empty;
        logic               persp;
        logic signed [31:0] c0x;
        logic signed [31:0] c0y;
        logic signed [31:0] c1x;
        logic signed [31:0] c1y;
        logic signed [31:0] c3x;
        logic signed [31:0] c3y;
        logic signed [31:0] rx0;
        logic signed [31:0] ry0;
        logic signed [32:0] span_x;
        logic signed [32:0] span_y;
        logic signed [32:0] ex1;
        logic signed [32:0] ey1;
        logic signed [32:0] ex2;
        logic signed [32:0] ey2;
        logic signed [33:0] ex3;
        logic signed [33:0] ey3;
    } t_job;

    typedef enum logic [5:0] {
        S_IDLE, S_CHECK,
        S_DD1, S_DD2, S_DDCHK,
        S_GN1, S_GN2, S_GDIV, S_HN1, S_HN2, S_HDIV, S_GHCHK,
        S_SIDE, S_U00, S_U01, S_U10, S_U11, S_UCHK,
        S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_DCHK,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_FCHK,
        S_DONE
    } t_state;

    function automatic t_wide sx32(logic signed [31:0] v);
        return {{(WW-32){v[31]}}, v};
    endfunction

    function automatic t_wide sx33(logic signed [32:0] v);
        return {{(WW-33){v[32]}}, v};
    endfunction

    function automatic t_wide sx34(logic signed [33:0] v);
        return {{(WW-34){v[33]}}, v};
    endfunction

    function automatic t_wide zx16(logic [TOL_W-1:0] v);
        return {{(WW-TOL_W){1'b0}}, v};
    endfunction

    function automatic t_wide wabs(t_wide v);
        return v[WW-1] ? -v : v;
    endfunction

    function automatic logic fits64(t_wide v);
        return (&v[WW-1:63]) || !(|v[WW-1:63]);
    endfunction

    function automatic t_wide to_matrix(t_wide e, t_wide f);
        t_wide s;
        s = (e <<< MATRIX_FRAC_BITS) + f;
        return s >>> COORD_FRAC_BITS;
    endfunction

endpackage

FILE: rtl/cphs_front.sv
// Input stage: register a quad beat, classify it and hand it to the job queue.
`timescale 1ns / 1ps
module cphs_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  cphs_pkg::t_in                i_data,
    input  logic [cphs_pkg::TOL_W-1:0]   i_aff_tol,
    input  logic                         i_q_full,
    output logic                         o_push,
    output cphs_pkg::t_job               o_job
);
    import cphs_pkg::*;

    logic               r_valid;
    t_in                r_in;
    logic signed [34:0] ax3;
    logic signed [34:0] ay3;
    logic signed [34:0] tol35;

    assign o_stall = r_valid && i_q_full;
    assign o_push  = r_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    always_comb begin
        o_job.c0x    = r_in.corner0_x;
        o_job.c0y    = r_in.corner0_y;
        o_job.c1x    = r_in.corner1_x;
        o_job.c1y    = r_in.corner1_y;
        o_job.c3x    = r_in.corner3_x;
        o_job.c3y    = r_in.corner3_y;
        o_job.rx0    = r_in.rect_min_x;
        o_job.ry0    = r_in.rect_min_y;
        o_job.span_x = $signed({r_in.rect_max_x[31], r_in.rect_max_x})
                     - $signed({r_in.rect_min_x[31], r_in.rect_min_x});
        o_job.span_y = $signed({r_in.rect_max_y[31], r_in.rect_max_y})
                     - $signed({r_in.rect_min_y[31], r_in.rect_min_y});
        o_job.ex1    = $signed({r_in.corner1_x[31], r_in.corner1_x})
                     - $signed({r_in.corner2_x[31], r_in.corner2_x});
        o_job.ey1    = $signed({r_in.corner1_y[31], r_in.corner1_y})
                     - $signed({r_in.corner2_y[31], r_in.corner2_y});
        o_job.ex2    = $signed({r_in.corner3_x[31], r_in.corner3_x})
                     - $signed({r_in.corner2_x[31], r_in.corner2_x});
        o_job.ey2    = $signed({r_in.corner3_y[31], r_in.corner3_y})
                     - $signed({r_in.corner2_y[31], r_in.corner2_y});
        o_job.ex3    = $signed({{2{r_in.corner0_x[31]}}, r_in.corner0_x})
                     - $signed({{2{r_in.corner1_x[31]}}, r_in.corner1_x})
                     + $signed({{2{r_in.corner2_x[31]}}, r_in.corner2_x})
                     - $signed({{2{r_in.corner3_x[31]}}, r_in.corner3_x});
        o_job.ey3    = $signed({{2{r_in.corner0_y[31]}}, r_in.corner0_y})
                     - $signed({{2{r_in.corner1_y[31]}}, r_in.corner1_y})
                     + $signed({{2{r_in.corner2_y[31]}}, r_in.corner2_y})
                     - $signed({{2{r_in.corner3_y[31]}}, r_in.corner3_y});
        ax3          = $signed({o_job.ex3[33], o_job.ex3});
        ay3          = $signed({o_job.ey3[33], o_job.ey3});
        if (ax3 < 0) begin
            ax3 = -ax3;
        end
        if (ay3 < 0) begin
            ay3 = -ay3;
        end
        tol35        = $signed({19'b0, i_aff_tol});
        o_job.empty  = (o_job.span_x <= 33'sd0) || (o_job.span_y <= 33'sd0);
        o_job.persp  = (ax3 > tol35) || (ay3 > tol35);
    end

endmodule

FILE: rtl/cphs_queue.sv
// Short job queue between the classifying front and the solving back.
`timescale 1ns / 1ps
module cphs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cphs_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cphs_pkg::t_job  o_job
);
    import cphs_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: rtl/cphs_mdu.sv
// Shared bit-serial signed multiplier and restoring divider.
`timescale 1ns / 1ps
module cphs_mdu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cphs_pkg::t_mdu_req i_req,
    input  cphs_pkg::t_wide    i_a,
    input  cphs_pkg::t_wide    i_b,
    output logic               o_done,
    output cphs_pkg::t_wide    o_res
);
    import cphs_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    t_mdu_op                 r_op;
    logic [CNT_W-1:0]        r_cnt;
    t_wide                   r_acc;
    t_wide                   r_ma;
    logic [MUL_BITS-1:0]     r_mb;
    logic [DIV_NUM_BITS-1:0] r_num;
    logic [DIV_DEN_BITS-1:0] r_den;
    logic [DIV_DEN_BITS-1:0] r_rem;
    logic [DIV_NUM_BITS-1:0] r_quo;
    logic                    r_neg;
    t_wide                   r_res;

    t_wide                   addend;
    t_wide                   acc_n;
    logic [DIV_DEN_BITS-1:0] rem_sh;
    logic                    ge;
    logic [DIV_DEN_BITS-1:0] rem_n;
    logic [DIV_NUM_BITS-1:0] quo_n;
    t_wide                   quo_w;
    logic                    last;
    t_wide                   abs_a;
    t_wide                   abs_b;

    assign o_done = r_done;
    assign o_res  = r_res;

    always_comb begin
        addend = (r_cnt == CNT_W'(MUL_BITS - 1)) ? -r_ma : r_ma;
        acc_n  = r_mb[0] ? r_acc + addend : r_acc;
        rem_sh = {r_rem[DIV_DEN_BITS-2:0], r_num[DIV_NUM_BITS-1]};
        ge     = (rem_sh >= r_den);
        rem_n  = ge ? rem_sh - r_den : rem_sh;
        quo_n  = {r_quo[DIV_NUM_BITS-2:0], ge};
        quo_w  = {{(WW-DIV_NUM_BITS){1'b0}}, quo_n};
        last   = (r_op == MDU_MUL) ? (r_cnt == CNT_W'(MUL_BITS - 1))
                                   : (r_cnt == CNT_W'(DIV_NUM_BITS - 1));
        abs_a  = wabs(i_a);
        abs_b  = wabs(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= '0;
            r_acc <= '0;
            r_ma  <= i_a;
            r_mb  <= i_b[MUL_BITS-1:0];
            r_num <= abs_a[DIV_NUM_BITS-1:0];
            r_den <= abs_b[DIV_DEN_BITS-1:0];
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_a[WW-1] ^ i_b[WW-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_op == MDU_MUL) begin
                r_acc <= acc_n;
                r_ma  <= r_ma <<< 1;
                r_mb  <= r_mb >> 1;
            end else begin
                r_rem <= rem_n;
                r_quo <= quo_n;
                r_num <= r_num << 1;
            end
            if (last) begin
                if (r_op == MDU_MUL) begin
                    r_res <= acc_n;
                end else begin
                    r_res <= r_neg ? -quo_w : quo_w;
                end
            end
        end
    end

endmodule

FILE: rtl/cphs_back.sv
// Solver sequencer: runs one job through the shared unit and holds the result beat.
`timescale 1ns / 1ps
module cphs_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  cphs_pkg::t_job               i_job,
    output logic                         o_pop,
    input  logic [cphs_pkg::TOL_W-1:0]   i_sing_tol,
    input  logic [cphs_pkg::TOL_W-1:0]   i_side_tol,
    output logic                         o_res_valid,
    output cphs_pkg::t_out               o_res,
    input  logic                         i_res_stall
);
    import cphs_pkg::*;

    t_state      r_state;
    t_state      n_state;
    t_job        r_job;
    t_status     r_status;
    logic        r_issued;
    logic        r_fovf;
    logic [1:0]  r_row;
    t_wide       r_t;
    t_wide       r_a;
    t_wide       r_dd;
    t_wide       r_g;
    t_wide       r_h;
    t_wide       r_q00;
    t_wide       r_q01;
    t_wide       r_q02;
    t_wide       r_q10;
    t_wide       r_q11;
    t_wide       r_q12;
    logic signed [63:0] r_mc0 [3];
    logic signed [63:0] r_mc1 [3];
    logic signed [63:0] r_mc2 [3];
    logic        r_out_valid;
    t_out        r_out;

    t_mdu_req    md_req;
    t_wide       md_a;
    t_wide       md_b;
    logic        md_done;
    t_wide       md_res;
    logic        is_op;
    logic        out_free;
    t_wide       qa;
    t_wide       qb;
    t_wide       qc;
    t_wide       st;
    logic        side_bad;
    logic        u_ovf;
    t_wide       f5_val;

    cphs_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (md_a),
        .i_b     (md_b),
        .o_done  (md_done),
        .o_res   (md_res)
    );

    assign out_free    = !r_out_valid || !i_res_stall;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_pop       = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        case (r_row)
            2'd0: begin
                qa = r_q00;
                qb = r_q01;
                qc = r_q02;
            end
            2'd1: begin
                qa = r_q10;
                qb = r_q11;
                qc = r_q12;
            end
            default: begin
                qa = r_g;
                qb = r_h;
                qc = W_ONE;
            end
        endcase
        st       = zx16(i_side_tol);
        side_bad = !((W_ONE + r_g) > st) || !((W_ONE + r_g + r_h) > st)
                || !((W_ONE + r_h) > st);
        u_ovf    = !fits64(r_q00) || !fits64(r_q01) || !fits64(r_q02)
                || !fits64(r_q10) || !fits64(r_q11) || !fits64(r_q12);
        f5_val   = r_t - md_res;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_job_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (r_job.empty) begin
                    n_state = S_DONE;
                end else if (r_job.persp) begin
                    n_state = S_DD1;
                end else begin
                    n_state = S_SIDE;
                end
            end
            S_DD1:   if (md_done) n_state = S_DD2;
            S_DD2:   if (md_done) n_state = S_DDCHK;
            S_DDCHK: n_state = (wabs(r_dd) > zx16(i_sing_tol)) ? S_GN1 : S_DONE;
            S_GN1:   if (md_done) n_state = S_GN2;
            S_GN2:   if (md_done) n_state = S_GDIV;
            S_GDIV:  if (md_done) n_state = S_HN1;
            S_HN1:   if (md_done) n_state = S_HN2;
            S_HN2:   if (md_done) n_state = S_HDIV;
            S_HDIV:  if (md_done) n_state = S_GHCHK;
            S_GHCHK: n_state = (fits64(r_g) && fits64(r_h)) ? S_SIDE : S_DONE;
            S_SIDE:  n_state = side_bad ? S_DONE : S_U00;
            S_U00:   if (md_done) n_state = S_U01;
            S_U01:   if (md_done) n_state = S_U10;
            S_U10:   if (md_done) n_state = S_U11;
            S_U11:   if (md_done) n_state = S_UCHK;
            S_UCHK:  n_state = u_ovf ? S_DONE : S_D1;
            S_D1:    if (md_done) n_state = S_D2;
            S_D2:    if (md_done) n_state = S_D3;
            S_D3:    if (md_done) n_state = S_D4;
            S_D4:    if (md_done) n_state = S_D5;
            S_D5:    if (md_done) n_state = S_D6;
            S_D6:    if (md_done) n_state = S_D7;
            S_D7:    if (md_done) n_state = S_DCHK;
            S_DCHK:  n_state = (wabs(r_dd) > W_SING_LIM) ? S_F0 : S_DONE;
            S_F0:    if (md_done) n_state = S_F1;
            S_F1:    if (md_done) n_state = S_F2;
            S_F2:    if (md_done) n_state = S_F3;
            S_F3:    if (md_done) n_state = S_F4;
            S_F4:    if (md_done) n_state = S_F5;
            S_F5:    if (md_done) n_state = (r_row == 2'd2) ? S_FCHK : S_F0;
            S_FCHK:  n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        is_op     = 1'b1;
        md_req.op = MDU_MUL;
        md_a      = '0;
        md_b      = '0;
        case (r_state)
            S_DD1: begin md_a = sx33(r_job.ex1); md_b = sx33(r_job.ey2); end
            S_DD2: begin md_a = sx33(r_job.ex2); md_b = sx33(r_job.ey1); end
            S_GN1: begin md_a = sx34(r_job.ex3); md_b = sx33(r_job.ey2); end
            S_GN2: begin md_a = sx33(r_job.ex2); md_b = sx34(r_job.ey3); end
            S_HN1: begin md_a = sx33(r_job.ex1); md_b = sx34(r_job.ey3); end
            S_HN2: begin md_a = sx34(r_job.ex3); md_b = sx33(r_job.ey1); end
            S_GDIV, S_HDIV: begin
                md_req.op = MDU_DIV;
                md_a      = r_a;
                md_b      = r_dd;
            end
            S_U00: begin md_a = sx32(r_job.c1x); md_b = r_g; end
            S_U01: begin md_a = sx32(r_job.c3x); md_b = r_h; end
            S_U10: begin md_a = sx32(r_job.c1y); md_b = r_g; end
            S_U11: begin md_a = sx32(r_job.c3y); md_b = r_h; end
            S_D1:  begin md_a = r_q12; md_b = r_h;   end
            S_D2:  begin md_a = r_t;   md_b = r_q00; end
            S_D3:  begin md_a = r_q12; md_b = r_g;   end
            S_D4:  begin md_a = r_t;   md_b = r_q01; end
            S_D5:  begin md_a = r_q11; md_b = r_g;   end
            S_D6:  begin md_a = r_q10; md_b = r_h;   end
            S_D7:  begin md_a = r_t;   md_b = r_q02; end
            S_F0: begin
                md_req.op = MDU_DIV;
                md_a      = qa <<< COORD_FRAC_BITS;
                md_b      = sx33(r_job.span_x);
            end
            S_F1: begin
                md_req.op = MDU_DIV;
                md_a      = qb <<< COORD_FRAC_BITS;
                md_b      = sx33(r_job.span_y);
            end
            S_F2:  begin md_a = sx32(r_job.rx0); md_b = qa; end
            S_F3: begin
                md_req.op = MDU_DIV;
                md_a      = r_a;
                md_b      = sx33(r_job.span_x);
            end
            S_F4:  begin md_a = sx32(r_job.ry0); md_b = qb; end
            S_F5: begin
                md_req.op = MDU_DIV;
                md_a      = r_a;
                md_b      = sx33(r_job.span_y);
            end
            default: is_op = 1'b0;
        endcase
        md_req.start = is_op && !r_issued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (md_done) begin
                r_issued <= 1'b0;
            end else if (md_req.start) begin
                r_issued <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                end
            end
            S_CHECK: begin
                r_status <= r_job.empty ? ST_EMPTY : ST_OK;
                r_g      <= '0;
                r_h      <= '0;
                r_row    <= '0;
                r_fovf   <= 1'b0;
            end
            S_DD1:   if (md_done) r_t <= md_res;
            S_DD2:   if (md_done) r_dd <= r_t - md_res;
            S_DDCHK: if (!(wabs(r_dd) > zx16(i_sing_tol))) r_status <= ST_DEGEN;
            S_GN1:   if (md_done) r_t <= md_res;
            S_GN2:   if (md_done) r_a <= (r_t - md_res) <<< MATRIX_FRAC_BITS;
            S_GDIV:  if (md_done) r_g <= md_res;
            S_HN1:   if (md_done) r_t <= md_res;
            S_HN2:   if (md_done) r_a <= (r_t - md_res) <<< MATRIX_FRAC_BITS;
            S_HDIV:  if (md_done) r_h <= md_res;
            S_GHCHK: if (!(fits64(r_g) && fits64(r_h))) r_status <= ST_OVERFLOW;
            S_SIDE: begin
                r_q02 <= to_matrix(sx32(r_job.c0x), '0);
                r_q12 <= to_matrix(sx32(r_job.c0y), '0);
                if (side_bad) r_status <= ST_HORIZON;
            end
            S_U00: if (md_done) r_q00 <= to_matrix(sx32(r_job.c1x) - sx32(r_job.c0x), md_res);
            S_U01: if (md_done) r_q01 <= to_matrix(sx32(r_job.c3x) - sx32(r_job.c0x), md_res);
            S_U10: if (md_done) r_q10 <= to_matrix(sx32(r_job.c1y) - sx32(r_job.c0y), md_res);
            S_U11: if (md_done) r_q11 <= to_matrix(sx32(r_job.c3y) - sx32(r_job.c0y), md_res);
            S_UCHK: if (u_ovf) r_status <= ST_OVERFLOW;
            S_D1:  if (md_done) r_t <= (r_q11 <<< MATRIX_FRAC_BITS) - md_res;
            S_D2:  if (md_done) r_dd <= md_res;
            S_D3:  if (md_done) r_t <= (r_q10 <<< MATRIX_FRAC_BITS) - md_res;
            S_D4:  if (md_done) r_dd <= r_dd - md_res;
            S_D5:  if (md_done) r_a <= md_res;
            S_D6:  if (md_done) r_t <= md_res - r_a;
            S_D7:  if (md_done) r_dd <= r_dd + md_res;
            S_DCHK: if (!(wabs(r_dd) > W_SING_LIM)) r_status <= ST_SINGULAR;
            S_F0: begin
                if (md_done) begin
                    r_mc0[r_row] <= md_res[63:0];
                    if (!fits64(md_res)) r_fovf <= 1'b1;
                end
            end
            S_F1: begin
                if (md_done) begin
                    r_mc1[r_row] <= md_res[63:0];
                    if (!fits64(md_res)) r_fovf <= 1'b1;
                end
            end
            S_F2:  if (md_done) r_a <= md_res;
            S_F3:  if (md_done) r_t <= qc - md_res;
            S_F4:  if (md_done) r_a <= md_res;
            S_F5: begin
                if (md_done) begin
                    r_mc2[r_row] <= f5_val[63:0];
                    if (!fits64(f5_val)) r_fovf <= 1'b1;
                    r_row <= r_row + 1'b1;
                end
            end
            S_FCHK: r_status <= r_fovf ? ST_OVERFLOW : ST_OK;
            S_DONE: begin
                if (out_free) begin
                    r_out.status <= r_status;
                    if (r_status == ST_OK) begin
                        r_out.m00 <= r_mc0[0];
                        r_out.m01 <= r_mc1[0];
                        r_out.m02 <= r_mc2[0];
                        r_out.m10 <= r_mc0[1];
                        r_out.m11 <= r_mc1[1];
                        r_out.m12 <= r_mc2[1];
                        r_out.m20 <= r_mc0[2];
                        r_out.m21 <= r_mc1[2];
                        r_out.m22 <= r_mc2[2];
                    end else begin
                        r_out.m00 <= '0;
                        r_out.m01 <= '0;
                        r_out.m02 <= '0;
                        r_out.m10 <= '0;
                        r_out.m11 <= '0;
                        r_out.m12 <= '0;
                        r_out.m20 <= '0;
                        r_out.m21 <= '0;
                        r_out.m22 <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/corner_pin_homography_solve_top.sv
// Top level of the corner-pin homography solver: tolerance registers, front, queue and back.
`timescale 1ns / 1ps
// Accepts one quad beat (four destination corners and a source rectangle, Q20.12) and
// returns one beat holding the 3x3 projective matrix (Q24.40) and a status code. The
// front registers and classifies each quad and the back solves it through one shared
// bit-serial multiply/divide unit. A four-entry queue lets up to five quads be accepted
// while the back is busy, and the result register holds a finished beat while the next
// quad is solved.
// Tolerance registers reset to 1 and are written through the configuration port.
module corner_pin_homography_solve_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cphs_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cphs_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cphs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cphs_pkg::TOL_W-1:0]      i_cfg_data
);
    import cphs_pkg::*;

    logic [TOL_W-1:0] r_aff_tol;
    logic [TOL_W-1:0] r_sing_tol;
    logic [TOL_W-1:0] r_side_tol;
    logic             q_full;
    logic             q_push;
    logic             q_valid;
    logic             q_pop;
    t_job             f_job;
    t_job             q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aff_tol  <= TOL_W'(1);
            r_sing_tol <= TOL_W'(1);
            r_side_tol <= TOL_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_AFFINE_TOL:   r_aff_tol  <= i_cfg_data;
                CFG_SINGULAR_TOL: r_sing_tol <= i_cfg_data;
                CFG_SIDE_TOL:     r_side_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cphs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_data    (i_in_data),
        .i_aff_tol (r_aff_tol),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_job     (f_job)
    );

    cphs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    cphs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .i_sing_tol  (r_sing_tol),
        .i_side_tol  (r_side_tol),
        .o_res_valid (o_out_valid),
        .o_res       (o_out_data),
        .i_res_stall (i_out_stall)
    );

endmodule

FILE: rtl/cphs_checker.sv
// Port-level checks on the result channel of the solver, bound to the top level.
`timescale 1ns / 1ps
module cphs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input cphs_pkg::t_out o_out_data
);
    import cphs_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat visible after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_beat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result beat changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_OVERFLOW))
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
            o_out_data.m00 == 0 && o_out_data.m01 == 0 && o_out_data.m02 == 0 &&
            o_out_data.m10 == 0 && o_out_data.m11 == 0 && o_out_data.m12 == 0 &&
            o_out_data.m20 == 0 && o_out_data.m21 == 0 && o_out_data.m22 == 0)
        else $error("failed solve carries a non-zero matrix");

endmodule

bind corner_pin_homography_solve_top cphs_checker u_cphs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
